### rtl/core/psd_pkg.sv
// Shared widths, codes and item tags for the point-to-segment distance block.
package psd_pkg;

	localparam int COORD_W  = 32;  // Q16.16 coordinate
	localparam int DIFF_W   = 33;  // difference of two coordinates
	localparam int MAG_W    = 32;  // magnitude of a coordinate difference
	localparam int PROD_W   = 66;  // signed product of two differences
	localparam int DOT_W    = 66;  // signed dot product
	localparam int DD_W     = 65;  // squared segment length
	localparam int REM_W    = 66;  // division partial remainder, doubled
	localparam int T_W      = 33;  // projection parameter, Q1.32 in [0, 1]
	localparam int MX_W     = 64;  // magnitude times t
	localparam int SQ_W     = 65;  // squared distance, Q33.32
	localparam int TRIAL_W  = 67;  // root trial value
	localparam int ROOT_W   = 33;  // root, Q17.16
	localparam int REGION_W = 2;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [REGION_W-1:0] {
		REG_BEFORE   = 2'd0,
		REG_PAST     = 2'd1,
		REG_INTERIOR = 2'd2
	} region_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_X = 3'd0,
		CFG_START_Y = 3'd1,
		CFG_END_X   = 3'd2,
		CFG_END_Y   = 3'd3
	} cfg_idx_t;

	// Travels with an item through the divider cells.
	typedef struct packed {
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		region_t                   region;
		logic                      degen;
	} div_tag_t;

	// Travels with an item through the root cells.
	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		region_t                   region;
	} sqrt_tag_t;

endpackage

### rtl/core/psd_div_cell.sv
// One restoring-division cell: settles one quotient bit of t per item.
module psd_div_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        v_prev,
	input  logic [psd_pkg::REM_W-1:0]   rem_prev,
	input  logic [psd_pkg::T_W-1:0]     quo_prev,
	input  psd_pkg::div_tag_t           tag_prev,
	input  logic [psd_pkg::DD_W-1:0]    dd,
	output logic                        v_next,
	output logic [psd_pkg::REM_W-1:0]   rem_next,
	output logic [psd_pkg::T_W-1:0]     quo_next,
	output psd_pkg::div_tag_t           tag_next
);
	import psd_pkg::*;

	logic              v_q;
	logic [REM_W-1:0]  rem_q;
	logic [T_W-1:0]    quo_q;
	div_tag_t          tag_q;
	logic [REM_W:0]    diff;
	logic              ge;
	logic [REM_W-1:0]  keep;

	always_comb begin
		diff = {1'b0, rem_prev} - {{(REM_W+1-DD_W){1'b0}}, dd};
		ge   = ~diff[REM_W];
		keep = ge ? diff[REM_W-1:0] : rem_prev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_prev;
		end
	end

	// remainder leaves doubled, ready for the next bit
	always_ff @(posedge clk) begin
		rem_q <= {keep[REM_W-2:0], 1'b0};
		quo_q <= {quo_prev[T_W-2:0], ge};
		tag_q <= tag_prev;
	end

	assign v_next   = v_q;
	assign rem_next = rem_q;
	assign quo_next = quo_q;
	assign tag_next = tag_q;

endmodule

### rtl/core/psd_sqrt_cell.sv
// One digit-by-digit square root cell: settles root bit BIT per item.
module psd_sqrt_cell #(
	parameter int BIT = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        v_prev,
	input  logic [psd_pkg::SQ_W-1:0]    rem_prev,
	input  logic [psd_pkg::ROOT_W-1:0]  root_prev,
	input  psd_pkg::sqrt_tag_t          tag_prev,
	output logic                        v_next,
	output logic [psd_pkg::SQ_W-1:0]    rem_next,
	output logic [psd_pkg::ROOT_W-1:0]  root_next,
	output psd_pkg::sqrt_tag_t          tag_next
);
	import psd_pkg::*;

	localparam logic [ROOT_W-1:0]  BIT_MASK = ROOT_W'(1) << BIT;
	localparam logic [TRIAL_W-1:0] SQ_BIT   = TRIAL_W'(1) << (2 * BIT);

	logic               v_q;
	logic [SQ_W-1:0]    rem_q;
	logic [ROOT_W-1:0]  root_q;
	sqrt_tag_t          tag_q;
	logic [TRIAL_W-1:0] trial;
	logic [TRIAL_W:0]   diff;
	logic               ge;

	// (s + 2^b)^2 - s^2 = s*2^(b+1) + 2^(2b)
	always_comb begin
		trial = ({{(TRIAL_W-ROOT_W){1'b0}}, root_prev} << (BIT + 1)) | SQ_BIT;
		diff  = {{(TRIAL_W+1-SQ_W){1'b0}}, rem_prev} - {1'b0, trial};
		ge    = ~diff[TRIAL_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_prev;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= ge ? diff[SQ_W-1:0] : rem_prev;
		root_q <= ge ? (root_prev | BIT_MASK) : root_prev;
		tag_q  <= tag_prev;
	end

	assign v_next    = v_q;
	assign rem_next  = rem_q;
	assign root_next = root_q;
	assign tag_next  = tag_q;

endmodule

### rtl/core/point_to_segment_closest_distance.sv
// Top level: closest point on a configured segment and distance to it, one point per clock.
// The segment endpoints are written through cfg_we/cfg_index/cfg_data (index 0 start_x,
// 1 start_y, 2 end_x, 3 end_y, higher indexes ignored); the user must write them only while
// no item is in flight, which the block itself does not enforce. A point is taken whenever
// start is high; busy is never raised, so an item can enter every cycle. Each item comes
// back as a one-cycle done strobe with closest_x/closest_y, distance and region; the
// receiver cannot stall it. The pipeline holds two cell rows: 33 divider cells that produce
// the projection parameter t one bit per cell, and 33 root cells that produce the distance
// one bit per cell, plus ten stages of multiply, add and select around them.
module point_to_segment_closest_distance (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [psd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [psd_pkg::COORD_W-1:0]           cfg_data,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [psd_pkg::COORD_W-1:0]    point_x,
	input  logic signed [psd_pkg::COORD_W-1:0]    point_y,
	output logic                                  done,
	output logic signed [psd_pkg::COORD_W-1:0]    closest_x,
	output logic signed [psd_pkg::COORD_W-1:0]    closest_y,
	output logic [psd_pkg::ROOT_W-1:0]            distance,
	output logic [psd_pkg::REGION_W-1:0]          region
);
	import psd_pkg::*;

	// ---------------- segment registers and values derived from them ----------------
	logic signed [COORD_W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic signed [DIFF_W-1:0]  dx_c, dy_c;
	logic [MAG_W-1:0]          adx_c, ady_c;
	logic signed [PROD_W-1:0]  dxsq_c, dysq_c;
	logic [MX_W-1:0]           dxsq_q, dysq_q;
	logic [DD_W-1:0]           dd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_X: start_x_q <= cfg_data;
				CFG_START_Y: start_y_q <= cfg_data;
				CFG_END_X:   end_x_q   <= cfg_data;
				CFG_END_Y:   end_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Segment direction; the stages that need it read it directly, relying on it staying stable while items are in flight.
	always_comb begin
		dx_c   = DIFF_W'(end_x_q) - DIFF_W'(start_x_q);
		dy_c   = DIFF_W'(end_y_q) - DIFF_W'(start_y_q);
		adx_c  = dx_c[DIFF_W-1] ? MAG_W'(-dx_c) : MAG_W'(dx_c);
		ady_c  = dy_c[DIFF_W-1] ? MAG_W'(-dy_c) : MAG_W'(dy_c);
		dxsq_c = dx_c * dx_c;
		dysq_c = dy_c * dy_c;
	end

	// dd follows a write through dxsq_q/dysq_q and then dd_q, ready before an item reaches the classify stage
	always_ff @(posedge clk) begin
		dxsq_q <= dxsq_c[MX_W-1:0];
		dysq_q <= dysq_c[MX_W-1:0];
		dd_q   <= {1'b0, dxsq_q} + {1'b0, dysq_q};
	end

	assign busy = 1'b0;

	// ---------------- s1: offsets from segment start ----------------
	logic                      v_s1, v_s2, v_s3;
	logic signed [DIFF_W-1:0]  ux_s1, uy_s1;
	logic signed [COORD_W-1:0] px_s1, py_s1, px_s2, py_s2, px_s3, py_s3;
	logic signed [PROD_W-1:0]  pxd_s2, pyd_s2;
	logic signed [DOT_W-1:0]   dot_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ux_s1  <= DIFF_W'(point_x) - DIFF_W'(start_x_q);
		uy_s1  <= DIFF_W'(point_y) - DIFF_W'(start_y_q);
		px_s1  <= point_x;
		py_s1  <= point_y;
		// s2: the two dot-product terms
		pxd_s2 <= ux_s1 * dx_c;
		pyd_s2 <= uy_s1 * dy_c;
		px_s2  <= px_s1;
		py_s2  <= py_s1;
		// s3: dot((p - start), d)
		dot_s3 <= pxd_s2 + pyd_s2;
		px_s3  <= px_s2;
		py_s3  <= py_s2;
	end

	// ---------------- classify ----------------
	// dot(p - end, d) = dot1 - dd, so "past the end" is dot1 > dd.
	region_t  region_c;
	div_tag_t tag_c;

	always_comb begin
		priority if (dot_s3[DOT_W-1]) begin
			region_c = REG_BEFORE;
		end else if ($unsigned(dot_s3) > {1'b0, dd_q}) begin
			region_c = REG_PAST;
		end else begin
			region_c = REG_INTERIOR;
		end
		tag_c.px     = px_s3;
		tag_c.py     = py_s3;
		tag_c.region = region_c;
		tag_c.degen  = (dd_q == '0);
	end

	// ---------------- divider row: t = dot1 * 2^32 / dd ----------------
	// In the interior dot1 <= dd, so t needs 33 bits and the first cell starts from dot1.
	logic              div_v   [0:T_W];
	logic [REM_W-1:0]  div_rem [0:T_W];
	logic [T_W-1:0]    div_quo [0:T_W];
	div_tag_t          div_tag [0:T_W];

	assign div_v[0]   = v_s3;
	assign div_rem[0] = $unsigned(dot_s3);
	assign div_quo[0] = '0;
	assign div_tag[0] = tag_c;

	genvar g;
	generate
		for (g = 0; g < T_W; g++) begin : g_div
			psd_div_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.v_prev   (div_v[g]),
				.rem_prev (div_rem[g]),
				.quo_prev (div_quo[g]),
				.tag_prev (div_tag[g]),
				.dd       (dd_q),
				.v_next   (div_v[g+1]),
				.rem_next (div_rem[g+1]),
				.quo_next (div_quo[g+1]),
				.tag_next (div_tag[g+1])
			);
		end
	endgenerate

	// ---------------- s4..s9: round t, scale, closest point, squared error ----------------
	logic                      v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic [T_W-1:0]            t_s4;
	div_tag_t                  tag_s4, tag_s5;
	logic [MX_W-1:0]           mx_s5, my_s5;
	logic [MX_W-1:0]           mx_rnd, my_rnd;
	logic [MAG_W-1:0]          offx_c, offy_c;
	logic signed [COORD_W-1:0] cx_c, cy_c;
	logic signed [COORD_W-1:0] px_s6, py_s6;
	sqrt_tag_t                 ctag_s6, ctag_s7, ctag_s8, ctag_s9;
	logic signed [DIFF_W-1:0]  ex_c, ey_c;
	logic [MAG_W-1:0]          ex_s7, ey_s7;
	logic [MX_W-1:0]           sqx_s8, sqy_s8;
	logic [SQ_W-1:0]           sq_s9;
	logic                      rnd_up;

	// last cell hands over the doubled remainder: round half up when 2*rem >= dd
	assign rnd_up = (div_rem[T_W] >= {1'b0, dd_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s4 <= div_v[T_W];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// offset = round(|d| * t / 2^32), ties away from zero, then signed like d
	always_comb begin
		mx_rnd = mx_s5 + MX_W'(64'h8000_0000);
		my_rnd = my_s5 + MX_W'(64'h8000_0000);
		offx_c = mx_rnd[MX_W-1:MX_W-MAG_W];
		offy_c = my_rnd[MX_W-1:MX_W-MAG_W];
		unique case (tag_s5.region)
			REG_BEFORE: begin
				cx_c = start_x_q;
				cy_c = start_y_q;
			end
			REG_PAST: begin
				cx_c = end_x_q;
				cy_c = end_y_q;
			end
			default: begin
				cx_c = dx_c[DIFF_W-1] ? start_x_q - $signed(offx_c) : start_x_q + $signed(offx_c);
				cy_c = dy_c[DIFF_W-1] ? start_y_q - $signed(offy_c) : start_y_q + $signed(offy_c);
			end
		endcase
		ex_c = DIFF_W'(px_s6) - DIFF_W'(ctag_s6.cx);
		ey_c = DIFF_W'(py_s6) - DIFF_W'(ctag_s6.cy);
	end

	always_ff @(posedge clk) begin
		// s4: zero-length segment pins t to 0, which leaves the closest point at start
		t_s4   <= div_tag[T_W].degen ? '0 : div_quo[T_W] + T_W'(rnd_up);
		tag_s4 <= div_tag[T_W];
		// s5
		mx_s5  <= MX_W'(adx_c) * MX_W'(t_s4);
		my_s5  <= MX_W'(ady_c) * MX_W'(t_s4);
		tag_s5 <= tag_s4;
		// s6
		ctag_s6.cx     <= cx_c;
		ctag_s6.cy     <= cy_c;
		ctag_s6.region <= tag_s5.region;
		px_s6          <= tag_s5.px;
		py_s6          <= tag_s5.py;
		// s7: error magnitudes
		ex_s7   <= ex_c[DIFF_W-1] ? MAG_W'(-ex_c) : MAG_W'(ex_c);
		ey_s7   <= ey_c[DIFF_W-1] ? MAG_W'(-ey_c) : MAG_W'(ey_c);
		ctag_s7 <= ctag_s6;
		// s8
		sqx_s8  <= MX_W'(ex_s7) * MX_W'(ex_s7);
		sqy_s8  <= MX_W'(ey_s7) * MX_W'(ey_s7);
		ctag_s8 <= ctag_s7;
		// s9: Q33.32 squared distance
		sq_s9   <= {1'b0, sqx_s8} + {1'b0, sqy_s8};
		ctag_s9 <= ctag_s8;
	end

	// ---------------- root row: one result bit per cell, MSB first ----------------
	logic              sq_v    [0:ROOT_W];
	logic [SQ_W-1:0]   sq_rem  [0:ROOT_W];
	logic [ROOT_W-1:0] sq_root [0:ROOT_W];
	sqrt_tag_t         sq_tag  [0:ROOT_W];

	assign sq_v[0]    = v_s9;
	assign sq_rem[0]  = sq_s9;
	assign sq_root[0] = '0;
	assign sq_tag[0]  = ctag_s9;

	generate
		for (g = 0; g < ROOT_W; g++) begin : g_sqrt
			psd_sqrt_cell #(
				.BIT (ROOT_W - 1 - g)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.v_prev    (sq_v[g]),
				.rem_prev  (sq_rem[g]),
				.root_prev (sq_root[g]),
				.tag_prev  (sq_tag[g]),
				.v_next    (sq_v[g+1]),
				.rem_next  (sq_rem[g+1]),
				.root_next (sq_root[g+1]),
				.tag_next  (sq_tag[g+1])
			);
		end
	endgenerate

	// ---------------- output register ----------------
	// round to nearest: bump when the leftover exceeds the root
	logic                      done_q;
	logic signed [COORD_W-1:0] closest_x_q, closest_y_q;
	logic [ROOT_W-1:0]         distance_q;
	logic [REGION_W-1:0]       region_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= sq_v[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		closest_x_q <= sq_tag[ROOT_W].cx;
		closest_y_q <= sq_tag[ROOT_W].cy;
		region_q    <= sq_tag[ROOT_W].region;
		distance_q  <= (sq_rem[ROOT_W] > SQ_W'(sq_root[ROOT_W])) ?
			sq_root[ROOT_W] + ROOT_W'(1) : sq_root[ROOT_W];
	end

	assign done      = done_q;
	assign closest_x = closest_x_q;
	assign closest_y = closest_y_q;
	assign distance  = distance_q;
	assign region    = region_q;

endmodule

### tb/tb_top.sv
// Testbench for point_to_segment_closest_distance: scoreboard, stimulus and checks.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import psd_pkg::*;

	// Drain wait: the block latency plus some slack.
	localparam int DRAIN_CYCLES = 90;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int N_PHASES     = 6;
	localparam int PHASE_ITEMS  = 250;

	typedef struct {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [ROOT_W-1:0]         dist_val;
		logic [REGION_W-1:0]       reg_code;
	} nearest_t;

	// Scoreboard: holds its own copy of the segment and predicts every item.
	class nearest_sb;
		longint   seg_sx, seg_sy, seg_ex, seg_ey;
		nearest_t pending[$];
		int       errors;
		int       n_checked;
		int       n_region[3];

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
			longint v;
			v = longint'($signed(val));
			case (idx)
				CFG_START_X: seg_sx = v;
				CFG_START_Y: seg_sy = v;
				CFG_END_X:   seg_ex = v;
				CFG_END_Y:   seg_ey = v;
				default: ; // other indexes are ignored by the block
			endcase
		endfunction

		// sign(dc) * round(|dc| * t / 2^32), ties away from zero
		function longint offset_of(longint dc, logic [127:0] t);
			logic [127:0] m;
			longint       s;
			m = (dc < 0 ? -dc : dc);
			m = m * t + 128'h8000_0000;
			s = longint'(m[64:32]);
			return dc < 0 ? -s : s;
		endfunction

		// root of a Q33.32 value, rounded to nearest
		function logic [ROOT_W-1:0] root_of(logic [127:0] v);
			logic [127:0] s, c;
			s = 0;
			for (int b = 33; b >= 0; b--) begin
				c = s | (128'd1 << b);
				if (c * c <= v)
					s = c;
			end
			if (v - s * s > s)
				s = s + 1;
			return s[ROOT_W-1:0];
		endfunction

		function void note(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
			longint              px, py, dx, dy, cx, cy, ex, ey;
			logic signed [127:0] dot1, dot2, dd;
			logic [127:0]        num, q, r, sq;
			nearest_t            e;
			px = x; py = y;
			dx = seg_ex - seg_sx; dy = seg_ey - seg_sy;
			dot1 = 128'(px - seg_sx) * 128'(dx) + 128'(py - seg_sy) * 128'(dy);
			dot2 = 128'(px - seg_ex) * 128'(dx) + 128'(py - seg_ey) * 128'(dy);
			if (dot1 < 0) begin
				e.reg_code = REG_BEFORE; cx = seg_sx; cy = seg_sy;
			end else if (dot2 > 0) begin
				e.reg_code = REG_PAST; cx = seg_ex; cy = seg_ey;
			end else begin
				e.reg_code = REG_INTERIOR;
				dd = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
				if (dd == 0) begin
					// degenerate segment: nearest is the start point
					cx = seg_sx; cy = seg_sy;
				end else begin
					num = dot1 <<< 32;
					q = num / dd;
					r = num % dd;
					if ((r << 1) >= dd)
						q = q + 1; // t rounds to nearest, ties up
					cx = seg_sx + offset_of(dx, q);
					cy = seg_sy + offset_of(dy, q);
				end
			end
			ex = px - cx; ey = py - cy;
			sq = 128'(ex) * 128'(ex) + 128'(ey) * 128'(ey);
			e.cx = cx[31:0];
			e.cy = cy[31:0];
			e.dist_val = root_of(sq);
			pending.push_back(e);
		endfunction

		function void check(logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy,
				logic [ROOT_W-1:0] dist_val, logic [REGION_W-1:0] rg);
			nearest_t e;
			if (pending.size() == 0) begin
				$error("result with no item outstanding: cx=%0d cy=%0d", cx, cy);
				errors++;
				return;
			end
			e = pending.pop_front();
			n_checked++;
			if (e.reg_code < 3)
				n_region[e.reg_code]++;
			if (cx !== e.cx) begin
				$error("closest_x expected %0d got %0d", e.cx, cx); errors++;
			end
			if (cy !== e.cy) begin
				$error("closest_y expected %0d got %0d", e.cy, cy); errors++;
			end
			if (dist_val !== e.dist_val) begin
				$error("distance expected %0d got %0d", e.dist_val, dist_val); errors++;
			end
			if (rg !== e.reg_code) begin
				$error("region expected %0d got %0d", e.reg_code, rg); errors++;
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [COORD_W-1:0]        cfg_data = '0;
	logic                      start = 1'b0;
	logic                      busy;
	logic signed [COORD_W-1:0] point_x = '0;
	logic signed [COORD_W-1:0] point_y = '0;
	logic                      done;
	logic signed [COORD_W-1:0] closest_x;
	logic signed [COORD_W-1:0] closest_y;
	logic [ROOT_W-1:0]         distance;
	logic [REGION_W-1:0]       region;

	nearest_sb sb = new();
	int        cycles;
	bit        no_idle;

	point_to_segment_closest_distance uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Monitor: note accepted items and check strobed results at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note(point_x, point_y);
			if (done)
				sb.check(closest_x, closest_y, distance, region);
		end
	end

	// Register write, one cycle of enable; the model copy follows right away
	// since writes only happen with nothing in flight.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic set_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
			logic [31:0] ey);
		write_reg(CFG_START_X, sx);
		write_reg(CFG_START_Y, sy);
		write_reg(CFG_END_X, ex);
		write_reg(CFG_END_Y, ey);
	endtask

	// Drive one item after an optional gap; start stays high afterwards so
	// back-to-back items go every cycle.
	task automatic send_point(logic [31:0] x, logic [31:0] y, int gap);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		point_x <= x;
		point_y <= y;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_empty();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	// Full quiet: all results in, then the pipeline latency on top.
	task automatic drain();
		wait_empty();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] near(longint base, int span);
		longint off;
		off = longint'($urandom_range(0, 2 * span)) - span;
		return 32'(base + off);
	endfunction

	function automatic logic [31:0] pick_point(bit is_x);
		longint s, e;
		s = is_x ? sb.seg_sx : sb.seg_sy;
		e = is_x ? sb.seg_ex : sb.seg_ey;
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return near(s, 1 << 18);
			2: return near(e, 1 << 18);
			3: return near((s + e) / 2, 1 << 20);
			default: return near(s + ((e - s) * $urandom_range(0, 8)) / 8, 1 << 12);
		endcase
	endfunction

	task automatic random_segment(int kind);
		logic [31:0] sx, sy, ex, ey;
		sx = $urandom(); sy = $urandom(); ex = $urandom(); ey = $urandom();
		case (kind)
			0: ; // full range
			1: begin
				sx = near(0, 1 << 20); sy = near(0, 1 << 20);
				ex = near(0, 1 << 20); ey = near(0, 1 << 20);
			end
			2: begin
				ex = sx; ey = sy; // zero length
			end
			3: begin
				sx = 32'h8000_0000; sy = 32'h7fff_ffff;
				ex = 32'h7fff_ffff; ey = 32'h8000_0000;
			end
			default: ey = sy; // horizontal
		endcase
		// writes to unused indexes must not disturb anything
		write_reg(CFG_IDX_W'($urandom_range(4, 7)), $urandom());
		set_segment(sx, sy, ex, ey);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset segment is all zeros: degenerate case with extreme points.
		send_point(32'h0, 32'h0, 0);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 0);
		send_point(32'h8000_0000, 32'h8000_0000, 1);
		send_point(32'h8000_0000, 32'h7fff_ffff, 0);
		drain();

		// Longest possible diagonal.
		set_segment(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		send_point(32'h8000_0000, 32'h8000_0000, 0);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 0);
		send_point(32'h0, 32'h0, 0);
		send_point(32'h8000_0000, 32'h7fff_ffff, 2);
		send_point(32'h7fff_ffff, 32'h8000_0000, 0);
		drain();

		// Unit segment along x: each region, and both endpoints exactly.
		write_reg(CFG_IDX_W'(5), 32'hdead_beef);
		set_segment(32'h0, 32'h0, 32'h0001_0000, 32'h0);
		send_point(32'hffff_ffff, 32'h0005_0000, 0);
		send_point(32'h0002_0000, 32'hfffd_0000, 0);
		send_point(32'h0000_8000, 32'h0003_0000, 0);
		send_point(32'h0001_0000, 32'h0000_0000, 0);
		send_point(32'h0000_0000, 32'h0000_0000, 3);
		send_point(32'h0000_5555, 32'h8000_0000, 0);
		drain();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			random_segment(ph % 5);
			no_idle = (ph == 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 2 && i == PHASE_ITEMS / 2)
					wait_empty(); // sender holds off until the pipe is empty
				send_point(pick_point(1'b1), pick_point(1'b0),
					(no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
			end
			drain();
		end

		$display("checked %0d results over %0d segment settings", sb.n_checked, N_PHASES + 3);
		$display("regions seen: before %0d, past %0d, interior %0d",
			sb.n_region[0], sb.n_region[1], sb.n_region[2]);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
